### hdl/bls_pkg.sv
// Shared types, constants and codes for the backtracking line search block.
package bls_pkg;

  localparam int MAX_ROWS_DEF = 16;
  localparam int MAX_COLS_DEF = 16;

  localparam logic [63:0] LOSS_SAT = 64'hFFFF_FFFF_FFFF_FFFF;

  localparam logic       BACKTRACK_RST = 1'b1;
  localparam logic       USE_MATRIX_RST = 1'b0;
  localparam logic [4:0] ROWS_RST = 5'd16;
  localparam logic [4:0] COLS_RST = 5'd16;
  localparam logic [4:0] MAX_HALV_RST = 5'd20;

  // Request kinds on the input channel.
  localparam logic [2:0] KIND_A     = 3'd0;
  localparam logic [2:0] KIND_B     = 3'd1;
  localparam logic [2:0] KIND_X     = 3'd2;
  localparam logic [2:0] KIND_G     = 3'd3;
  localparam logic [2:0] KIND_START = 3'd4;

  typedef enum logic [2:0] {
    CFG_BACKTRACK = 3'd0,
    CFG_USE_MATRIX = 3'd1,
    CFG_ROWS = 3'd2,
    CFG_COLS = 3'd3,
    CFG_MAX_HALV = 3'd4
  } cfg_idx_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_BASE,
    ST_TRIAL
  } state_t;

  typedef struct packed {
    logic [2:0]         kind;
    logic [3:0]         row;
    logic [3:0]         col;
    logic signed [31:0] value;
  } bls_in_t;

  typedef struct packed {
    logic [30:0] step_size;
    logic [4:0]  halvings_done;
    logic        status;
  } bls_out_t;

  // Handshake between the controller and the loss evaluator.
  typedef struct packed {
    logic        go;
    logic [30:0] step;
    logic        use_matrix;
  } loss_req_t;

endpackage

### hdl/bls_ram.sv
// Generic single-port RAM with registered read data.
module bls_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    addr,
  input  logic [WIDTH-1:0] wdata,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

### hdl/bls_loss.sv
// Pipelined loss evaluator that streams the stored matrix and vectors.
module bls_loss
  import bls_pkg::*;
#(
  parameter int MAX_ROWS = MAX_ROWS_DEF,
  parameter int MAX_COLS = MAX_COLS_DEF,
  localparam int RW = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1,
  localparam int CW = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1,
  localparam int AW = (MAX_ROWS * MAX_COLS > 1) ? $clog2(MAX_ROWS * MAX_COLS) : 1
) (
  input  logic               clk,
  input  logic               rst_n,
  input  loss_req_t          req,
  input  logic [RW-1:0]      last_row,
  input  logic [CW-1:0]      last_col,
  output logic [AW-1:0]      a_addr,
  output logic [RW-1:0]      row_addr,
  output logic [CW-1:0]      col_addr,
  input  logic signed [31:0] a_data,
  input  logic signed [31:0] b_data,
  input  logic signed [31:0] x_data,
  input  logic signed [31:0] g_data,
  output logic               done,
  output logic [63:0]        loss
);

  logic          iss_r, mat_r;
  logic [RW-1:0] i_r;
  logic [CW-1:0] j_r;
  logic [30:0]   step_r;
  logic          first_c, last_c, fin_c;

  // Stage valids and flags.
  logic v1_r, v2_r, v3_r, v4_r, v5_r, v6_r, v7_r, done_r;
  logic f1_r, f2_r, f3_r, f4_r;
  logic l1_r, l2_r, l3_r, l4_r;
  logic n1_r, n2_r, n3_r, n4_r, n5_r, n6_r, n7_r;

  logic signed [31:0] a2_r, a3_r, b2_r, b3_r, b4_r, b5_r;
  logic signed [63:0] sg, q, q2_r;
  logic [63:0]        mag2;
  logic [47:0]        m2;
  logic               psat;
  logic signed [32:0] pt, pt3_r, opa;
  logic signed [65:0] prod;
  logic signed [63:0] prod4_r, acc_r, acc5_r;
  logic signed [64:0] acc_sum, r65;
  logic signed [63:0] r64;
  logic [63:0]        rmag;
  logic               acc_ovf, r_ovf, rsat;
  logic [31:0]        m6_r;
  logic [63:0]        sq7_r, sum_r;
  logic [64:0]        sum_add4, sum_add7;
  logic               sat_r;

  assign first_c = (j_r == '0);
  assign last_c = (j_r == last_col);
  assign fin_c = last_c && (!mat_r || i_r == last_row);
  assign a_addr = AW'(int'(i_r) * MAX_COLS + int'(j_r));
  assign row_addr = i_r;
  assign col_addr = j_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      iss_r <= 1'b0;
    end else if (req.go) begin
      iss_r <= 1'b1;
    end else if (iss_r && fin_c) begin
      iss_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (req.go) begin
      i_r <= '0;
      j_r <= '0;
      step_r <= req.step;
      mat_r <= req.use_matrix;
    end else if (iss_r) begin
      if (last_c) begin
        j_r <= '0;
        i_r <= i_r + 1'b1;
      end else begin
        j_r <= j_r + 1'b1;
      end
    end
  end

  // Stage 1: trial coordinate x*2^16 - step*g, exact.
  assign sg = $signed({1'b0, step_r}) * g_data;
  assign q = {{16{x_data[31]}}, x_data, 16'b0} - sg;

  // Stage 2: truncate the magnitude to Q16.16.
  assign mag2 = q2_r[63] ? 64'(-q2_r) : 64'(q2_r);
  assign m2 = mag2[63:16];
  assign psat = (m2 > 48'h8000_0000);
  assign pt = q2_r[63] ? -$signed({1'b0, m2[31:0]}) : $signed({1'b0, m2[31:0]});

  // Stage 3: one shared multiplier for A*pt or pt*pt.
  assign opa = mat_r ? 33'(a3_r) : pt3_r;
  assign prod = opa * pt3_r;

  // Stage 4: row accumulation or direct sum of squares.
  assign acc_sum = 65'(f4_r ? 64'sd0 : acc_r) + 65'(prod4_r);
  assign acc_ovf = (acc_sum[64] != acc_sum[63]);
  assign sum_add4 = {1'b0, sum_r} + {1'b0, prod4_r};

  // Row end: subtract the offset and truncate the residual.
  assign r65 = 65'(acc5_r) - 65'($signed({{16{b5_r[31]}}, b5_r, 16'b0}));
  assign r_ovf = (r65[64] != r65[63]);
  assign r64 = r65[63:0];
  assign rmag = r64[63] ? 64'(-r64) : 64'(r64);
  assign rsat = (rmag[63:48] != '0);
  assign sum_add7 = {1'b0, sum_r} + {1'b0, sq7_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      {v1_r, v2_r, v3_r, v4_r, v5_r, v6_r, v7_r, done_r} <= '0;
    end else begin
      v1_r <= iss_r;
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r;
      v5_r <= v4_r && mat_r && l4_r;
      v6_r <= v5_r;
      v7_r <= v6_r;
      done_r <= (v4_r && !mat_r && n4_r) || (v7_r && n7_r);
    end
  end

  always_ff @(posedge clk) begin
    f1_r <= first_c;
    l1_r <= last_c;
    n1_r <= fin_c;
    a2_r <= a_data;
    b2_r <= b_data;
    q2_r <= q;
    f2_r <= f1_r;
    l2_r <= l1_r;
    n2_r <= n1_r;
    pt3_r <= pt;
    a3_r <= a2_r;
    b3_r <= b2_r;
    f3_r <= f2_r;
    l3_r <= l2_r;
    n3_r <= n2_r;
    prod4_r <= prod[63:0];
    b4_r <= b3_r;
    f4_r <= f3_r;
    l4_r <= l3_r;
    n4_r <= n3_r;
    if (v4_r && mat_r) begin
      acc_r <= acc_sum[63:0];
    end
    acc5_r <= acc_sum[63:0];
    b5_r <= b4_r;
    n5_r <= n4_r;
    m6_r <= rmag[47:16];
    n6_r <= n5_r;
    sq7_r <= 64'(m6_r) * 64'(m6_r);
    n7_r <= n6_r;
  end

  // Running sum and sticky saturation flag for one evaluation.
  always_ff @(posedge clk) begin
    if (req.go) begin
      sum_r <= '0;
      sat_r <= 1'b0;
    end else begin
      if (v4_r && !mat_r) begin
        sum_r <= sum_add4[63:0];
      end
      if (v7_r) begin
        sum_r <= sum_add7[63:0];
      end
      if ((v2_r && psat) || (v4_r && !mat_r && sum_add4[64]) ||
          (v4_r && mat_r && acc_ovf) || (v5_r && (r_ovf || rsat)) ||
          (v7_r && sum_add7[64])) begin
        sat_r <= 1'b1;
      end
    end
  end

  assign done = done_r;
  assign loss = sat_r ? LOSS_SAT : {1'b0, sum_r[63:1]};

  a_go_idle: assert property (@(posedge clk) disable iff (!rst_n)
    req.go |-> !iss_r && !v1_r && !v4_r && !v7_r)
    else $error("loss evaluation started while busy");
  a_done_one: assert property (@(posedge clk) disable iff (!rst_n)
    done |=> !done)
    else $error("loss done held for two cycles");
  a_row_end: assert property (@(posedge clk) disable iff (!rst_n)
    v5_r |-> mat_r)
    else $error("row end stage active without matrix");

endmodule

### hdl/backtracking_line_search.sv
// Top level of the backtracking line search: stores, controller and result register.
//
//   channel | direction | handshake            | payload
//   in_     | input     | in_valid / in_stall  | bls_in_t  (kind, row, col, value)
//   out_    | output    | out_valid / out_stall| bls_out_t (step_size, halvings_done, status)
//   cfg_    | input     | cfg_we               | cfg_index, cfg_data
//
// A load request is written to its store when it is taken.
// A start request with backtracking on and a nonzero halving limit holds the block
// for (1 + trials) loss evaluations; each streams one store word a cycle through
// the evaluator pipeline: cols words without the matrix, rows*cols words with it.
// Reset is synchronous and clears control state and the registers only; the
// stores hold undefined data until loaded. A waiting result does not block
// loads; a start request stalls until the result register is empty.
module backtracking_line_search
  import bls_pkg::*;
#(
  parameter int MAX_ROWS = MAX_ROWS_DEF,
  parameter int MAX_COLS = MAX_COLS_DEF
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_stall,
  input  bls_in_t  in_data,
  output logic     out_valid,
  input  logic     out_stall,
  output bls_out_t out_data,
  input  logic       cfg_we,
  input  logic [2:0] cfg_index,
  input  logic [4:0] cfg_data
);

  localparam int RW = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int CW = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
  localparam int AW = (MAX_ROWS * MAX_COLS > 1) ? $clog2(MAX_ROWS * MAX_COLS) : 1;

  // Configuration registers.
  logic       bt_en_r, use_mat_r;
  logic [4:0] rows_r, cols_r, max_h_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bt_en_r <= BACKTRACK_RST;
      use_mat_r <= USE_MATRIX_RST;
      rows_r <= ROWS_RST;
      cols_r <= COLS_RST;
      max_h_r <= MAX_HALV_RST;
    end else if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_BACKTRACK: bt_en_r <= cfg_data[0];
        CFG_USE_MATRIX: use_mat_r <= cfg_data[0];
        CFG_ROWS: rows_r <= cfg_data;
        CFG_COLS: cols_r <= cfg_data;
        CFG_MAX_HALV: max_h_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // A count of zero acts as one and a count past the store size is clamped,
  // so the evaluator only sees the last row and column index.
  logic [RW-1:0] last_row;
  logic [CW-1:0] last_col;

  always_comb begin
    if (rows_r == '0) begin
      last_row = '0;
    end else if (int'(rows_r) > MAX_ROWS) begin
      last_row = RW'(MAX_ROWS - 1);
    end else begin
      last_row = RW'(int'(rows_r) - 1);
    end
    if (cols_r == '0) begin
      last_col = '0;
    end else if (int'(cols_r) > MAX_COLS) begin
      last_col = CW'(MAX_COLS - 1);
    end else begin
      last_col = CW'(int'(cols_r) - 1);
    end
  end

  // Controller state.
  state_t      state_r, state_nxt;
  logic [30:0] step_r, step_nxt;
  logic [4:0]  halv_r, halv_nxt;
  logic [63:0] base_r, base_nxt;
  logic        out_valid_r, out_valid_nxt;
  bls_out_t    out_data_r, out_data_nxt;
  loss_req_t   req_r, req_nxt;

  logic        in_fire, is_start, idle;
  logic        loss_done;
  logic [63:0] loss;
  logic [30:0] half_step;
  logic [4:0]  halv_inc;

  assign idle = (state_r == ST_IDLE);
  assign is_start = (in_data.kind == KIND_START);
  // A start request waits until the result register is free.
  assign in_stall = !idle || (is_start && out_valid_r);
  assign in_fire = in_valid && !in_stall;
  assign half_step = step_r >> 1;
  assign halv_inc = halv_r + 5'd1;

  always_comb begin
    state_nxt = state_r;
    step_nxt = step_r;
    halv_nxt = halv_r;
    base_nxt = base_r;
    out_data_nxt = out_data_r;
    out_valid_nxt = out_valid_r && out_stall;
    req_nxt = '{go: 1'b0, step: req_r.step, use_matrix: use_mat_r};
    unique case (state_r)
      ST_IDLE: begin
        if (in_fire && is_start) begin
          halv_nxt = '0;
          if (in_data.value[31] || in_data.value == '0) begin
            // A step that is not positive is reported as an error.
            step_nxt = '0;
            out_data_nxt = '{step_size: '0, halvings_done: '0, status: 1'b1};
            out_valid_nxt = 1'b1;
          end else begin
            step_nxt = in_data.value[30:0];
            if (bt_en_r && max_h_r != '0) begin
              // First evaluation is the base loss at step zero.
              req_nxt.go = 1'b1;
              req_nxt.step = '0;
              state_nxt = ST_BASE;
            end else begin
              out_data_nxt = '{step_size: in_data.value[30:0], halvings_done: '0,
                               status: 1'b0};
              out_valid_nxt = 1'b1;
            end
          end
        end
      end
      ST_BASE: begin
        if (loss_done) begin
          base_nxt = loss;
          req_nxt.go = 1'b1;
          req_nxt.step = step_r;
          state_nxt = ST_TRIAL;
        end
      end
      ST_TRIAL: begin
        if (loss_done) begin
          if (loss <= base_r || loss == LOSS_SAT) begin
            out_data_nxt = '{step_size: step_r, halvings_done: halv_r, status: 1'b0};
            out_valid_nxt = 1'b1;
            state_nxt = ST_IDLE;
          end else begin
            step_nxt = half_step;
            halv_nxt = halv_inc;
            if (halv_inc == max_h_r) begin
              out_data_nxt = '{step_size: half_step, halvings_done: halv_inc,
                               status: 1'b0};
              out_valid_nxt = 1'b1;
              state_nxt = ST_IDLE;
            end else begin
              req_nxt.go = 1'b1;
              req_nxt.step = half_step;
            end
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      out_valid_r <= 1'b0;
      req_r.go <= 1'b0;
      step_r <= '0;
      halv_r <= '0;
      base_r <= '0;
    end else begin
      state_r <= state_nxt;
      out_valid_r <= out_valid_nxt;
      req_r.go <= req_nxt.go;
      step_r <= step_nxt;
      halv_r <= halv_nxt;
      base_r <= base_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
    req_r.step <= req_nxt.step;
    req_r.use_matrix <= req_nxt.use_matrix;
  end

  assign out_valid = out_valid_r;
  assign out_data = out_data_r;

  // Stores: written by load requests while idle, read by the evaluator.
  logic          row_ok, col_ok;
  logic          we_a, we_b, we_x, we_g;
  logic [AW-1:0] a_addr, lu_a_addr;
  logic [RW-1:0] row_addr, lu_row_addr;
  logic [CW-1:0] col_addr, lu_col_addr;
  logic [31:0]   a_q, b_q, x_q, g_q;

  assign row_ok = (int'(in_data.row) < MAX_ROWS);
  assign col_ok = (int'(in_data.col) < MAX_COLS);
  assign we_a = in_fire && in_data.kind == KIND_A && row_ok && col_ok;
  assign we_b = in_fire && in_data.kind == KIND_B && row_ok;
  assign we_x = in_fire && in_data.kind == KIND_X && col_ok;
  assign we_g = in_fire && in_data.kind == KIND_G && col_ok;

  assign a_addr = idle ? AW'(int'(in_data.row) * MAX_COLS + int'(in_data.col)) : lu_a_addr;
  assign row_addr = idle ? RW'(in_data.row) : lu_row_addr;
  assign col_addr = idle ? CW'(in_data.col) : lu_col_addr;

  bls_ram #(.WIDTH(32), .DEPTH(MAX_ROWS * MAX_COLS)) u_mat_ram (
    .clk(clk), .we(we_a), .addr(a_addr), .wdata(in_data.value), .rdata(a_q)
  );
  bls_ram #(.WIDTH(32), .DEPTH(MAX_ROWS)) u_b_ram (
    .clk(clk), .we(we_b), .addr(row_addr), .wdata(in_data.value), .rdata(b_q)
  );
  bls_ram #(.WIDTH(32), .DEPTH(MAX_COLS)) u_x_ram (
    .clk(clk), .we(we_x), .addr(col_addr), .wdata(in_data.value), .rdata(x_q)
  );
  bls_ram #(.WIDTH(32), .DEPTH(MAX_COLS)) u_g_ram (
    .clk(clk), .we(we_g), .addr(col_addr), .wdata(in_data.value), .rdata(g_q)
  );

  bls_loss #(.MAX_ROWS(MAX_ROWS), .MAX_COLS(MAX_COLS)) u_loss (
    .clk(clk),
    .rst_n(rst_n),
    .req(req_r),
    .last_row(last_row),
    .last_col(last_col),
    .a_addr(lu_a_addr),
    .row_addr(lu_row_addr),
    .col_addr(lu_col_addr),
    .a_data(a_q),
    .b_data(b_q),
    .x_data(x_q),
    .g_data(g_q),
    .done(loss_done),
    .loss(loss)
  );

  a_busy_stall: assert property (@(posedge clk) disable iff (!rst_n)
    !idle |-> in_stall)
    else $error("request accepted during a search");
  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.status |-> out_data.step_size == '0 &&
                                     out_data.halvings_done == '0)
    else $error("error result carries a step");
  a_done_state: assert property (@(posedge clk) disable iff (!rst_n)
    loss_done |-> state_r == ST_BASE || state_r == ST_TRIAL)
    else $error("loss result outside a search");

endmodule
